[rtl/core/llds_pkg.sv]
// ----------------------------------------------------------------------------
// llds_pkg
// Shared types and constants for the least loaded device selector.
// ----------------------------------------------------------------------------
package llds_pkg;

  localparam int NUM_DEVICES_DEF = 16;
  localparam int COUNT_WIDTH_DEF = 16;

  localparam int CMD_W     = 2;
  localparam int IDX_W     = 4;
  localparam int MASK_W    = 16;
  localparam int ERR_W     = 2;
  localparam int OUT_CNT_W = 16;

  localparam logic [CMD_W-1:0] CMD_ATTACH = 2'd0;
  localparam logic [CMD_W-1:0] CMD_DETACH = 2'd1;
  localparam logic [CMD_W-1:0] CMD_SELECT = 2'd2;
  localparam logic [CMD_W-1:0] CMD_NONE   = 2'd3;

  localparam logic [ERR_W-1:0] ERR_NONE      = 2'd0;
  localparam logic [ERR_W-1:0] ERR_UNDERFLOW = 2'd1;
  localparam logic [ERR_W-1:0] ERR_OVERFLOW  = 2'd2;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_FETCH,
    ST_LOAD,
    ST_SCAN,
    ST_DRAIN,
    ST_APPLY
  } state_t;

  typedef struct packed {
    logic rd_en;
    logic wr_en;
  } mem_ctl_t;

endpackage

[rtl/core/llds_count_mem.sv]
// ----------------------------------------------------------------------------
// llds_count_mem
// Counter memory with one read and one write port, registered read data and
// per-entry valid bits so that never-written entries read as zero.
// ----------------------------------------------------------------------------
module llds_count_mem #(
  parameter int DEPTH   = llds_pkg::NUM_DEVICES_DEF,
  parameter int WIDTH   = llds_pkg::COUNT_WIDTH_DEF,
  parameter int ADDR_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  llds_pkg::mem_ctl_t   ctl,
  input  logic [ADDR_W-1:0]    rd_addr,
  input  logic [ADDR_W-1:0]    wr_addr,
  input  logic [WIDTH-1:0]     wr_data,
  output logic [WIDTH-1:0]     rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [DEPTH-1:0] valid_r;
  logic [WIDTH-1:0] rd_data_r;
  logic             rd_valid_r;

  always_ff @(posedge clk) begin
    if (ctl.wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (ctl.rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r    <= '0;
      rd_valid_r <= 1'b0;
    end else begin
      if (ctl.wr_en) begin
        valid_r[wr_addr] <= 1'b1;
      end
      if (ctl.rd_en) begin
        rd_valid_r <= valid_r[rd_addr];
      end
    end
  end

  assign rd_data = rd_valid_r ? rd_data_r : '0;

endmodule

[rtl/core/least_loaded_device_selector.sv]
// ----------------------------------------------------------------------------
// least_loaded_device_selector
// Per-device resource counters with attach, detach and least-loaded select.
// ----------------------------------------------------------------------------
// channel   ports                                        handshake
// input     in_cmd, in_device_index, in_candidate_mask   start high, busy low
// result    out_selected_device, out_found,              out_valid, one cycle
//           out_error_code, out_new_count
//
// attach/detach: read, load, write back; select: one counter read per cycle
// over min(16, NUM_DEVICES) counters, drain, then write back unless empty;
// unused command or device out of range: result straight from idle
// counters read as zero after reset through per-entry valid bits
// busy is the only stall; the receiver cannot stall, each result shows once and
// a new command may be taken in the out_valid cycle
// ----------------------------------------------------------------------------
module least_loaded_device_selector #(
  parameter int NUM_DEVICES = llds_pkg::NUM_DEVICES_DEF,
  parameter int COUNT_WIDTH = llds_pkg::COUNT_WIDTH_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             start,
  output logic                             busy,
  input  logic [llds_pkg::CMD_W-1:0]       in_cmd,
  input  logic [llds_pkg::IDX_W-1:0]       in_device_index,
  input  logic [llds_pkg::MASK_W-1:0]      in_candidate_mask,
  output logic                             out_valid,
  output logic [llds_pkg::IDX_W-1:0]       out_selected_device,
  output logic                             out_found,
  output logic [llds_pkg::ERR_W-1:0]       out_error_code,
  output logic [llds_pkg::OUT_CNT_W-1:0]   out_new_count
);

  localparam int ADDR_W = (NUM_DEVICES > 1) ? $clog2(NUM_DEVICES) : 1;
  localparam int SCAN_N = (NUM_DEVICES < llds_pkg::MASK_W) ? NUM_DEVICES
                                                           : llds_pkg::MASK_W;
  localparam logic [llds_pkg::IDX_W-1:0] SCAN_LAST = llds_pkg::IDX_W'(SCAN_N - 1);

  llds_pkg::state_t               state_r, state_nxt;
  logic [llds_pkg::CMD_W-1:0]     cmd_r, cmd_nxt;
  logic [llds_pkg::IDX_W-1:0]     dev_r, dev_nxt;
  logic [llds_pkg::MASK_W-1:0]    mask_r, mask_nxt;
  logic [llds_pkg::IDX_W-1:0]     scan_idx_r, scan_idx_nxt;
  logic                           pend_r, pend_nxt;
  logic [llds_pkg::IDX_W-1:0]     pend_idx_r, pend_idx_nxt;
  logic                           have_r, have_nxt;
  logic [llds_pkg::IDX_W-1:0]     best_idx_r, best_idx_nxt;
  logic [COUNT_WIDTH-1:0]         best_cnt_r, best_cnt_nxt;

  logic                           out_valid_r, out_valid_nxt;
  logic [llds_pkg::IDX_W-1:0]     out_dev_r, out_dev_nxt;
  logic                           out_found_r, out_found_nxt;
  logic [llds_pkg::ERR_W-1:0]     out_err_r, out_err_nxt;
  logic [llds_pkg::OUT_CNT_W-1:0] out_cnt_r, out_cnt_nxt;

  llds_pkg::mem_ctl_t             mem_ctl;
  logic [ADDR_W-1:0]              rd_addr;
  logic [ADDR_W-1:0]              wr_addr;
  logic [COUNT_WIDTH-1:0]         wr_data;
  logic [COUNT_WIDTH-1:0]         rd_cnt;

  llds_count_mem #(
    .DEPTH  (NUM_DEVICES),
    .WIDTH  (COUNT_WIDTH),
    .ADDR_W (ADDR_W)
  ) u_count_mem (
    .clk     (clk),
    .rst_n   (rst_n),
    .ctl     (mem_ctl),
    .rd_addr (rd_addr),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_data (rd_cnt)
  );

  always_comb begin
    logic [COUNT_WIDTH-1:0]     upd_cnt;
    logic [llds_pkg::ERR_W-1:0] upd_err;

    state_nxt     = state_r;
    cmd_nxt       = cmd_r;
    dev_nxt       = dev_r;
    mask_nxt      = mask_r;
    scan_idx_nxt  = scan_idx_r;
    pend_nxt      = 1'b0;
    pend_idx_nxt  = pend_idx_r;
    have_nxt      = have_r;
    best_idx_nxt  = best_idx_r;
    best_cnt_nxt  = best_cnt_r;
    out_valid_nxt = 1'b0;
    out_dev_nxt   = out_dev_r;
    out_found_nxt = out_found_r;
    out_err_nxt   = out_err_r;
    out_cnt_nxt   = out_cnt_r;
    mem_ctl       = '0;
    rd_addr       = ADDR_W'(scan_idx_r);
    wr_addr       = ADDR_W'(best_idx_r);
    upd_cnt       = best_cnt_r;
    upd_err       = llds_pkg::ERR_NONE;

    // compare the counter that arrived from the scan read
    if (pend_r && mask_r[pend_idx_r] && (!have_r || (rd_cnt < best_cnt_r))) begin
      have_nxt     = 1'b1;
      best_idx_nxt = pend_idx_r;
      best_cnt_nxt = rd_cnt;
    end

    case (state_r)
      llds_pkg::ST_IDLE: begin
        if (start) begin
          cmd_nxt  = in_cmd;
          dev_nxt  = in_device_index;
          mask_nxt = in_candidate_mask;
          case (in_cmd)
            llds_pkg::CMD_ATTACH, llds_pkg::CMD_DETACH: begin
              if (32'(in_device_index) < NUM_DEVICES) begin
                state_nxt = llds_pkg::ST_FETCH;
              end else begin
                out_valid_nxt = 1'b1;
                out_dev_nxt   = in_device_index;
                out_found_nxt = 1'b0;
                out_err_nxt   = llds_pkg::ERR_NONE;
                out_cnt_nxt   = '0;
              end
            end
            llds_pkg::CMD_SELECT: begin
              have_nxt     = 1'b0;
              scan_idx_nxt = '0;
              state_nxt    = llds_pkg::ST_SCAN;
            end
            default: begin
              out_valid_nxt = 1'b1;
              out_dev_nxt   = '0;
              out_found_nxt = 1'b0;
              out_err_nxt   = llds_pkg::ERR_NONE;
              out_cnt_nxt   = '0;
            end
          endcase
        end
      end
      llds_pkg::ST_FETCH: begin
        mem_ctl.rd_en = 1'b1;
        rd_addr       = ADDR_W'(dev_r);
        state_nxt     = llds_pkg::ST_LOAD;
      end
      llds_pkg::ST_LOAD: begin
        best_cnt_nxt = rd_cnt;
        best_idx_nxt = dev_r;
        state_nxt    = llds_pkg::ST_APPLY;
      end
      llds_pkg::ST_SCAN: begin
        mem_ctl.rd_en = 1'b1;
        pend_nxt      = 1'b1;
        pend_idx_nxt  = scan_idx_r;
        if (scan_idx_r == SCAN_LAST) begin
          state_nxt = llds_pkg::ST_DRAIN;
        end else begin
          scan_idx_nxt = scan_idx_r + 1'b1;
        end
      end
      llds_pkg::ST_DRAIN: begin
        if (have_nxt) begin
          state_nxt = llds_pkg::ST_APPLY;
        end else begin
          out_valid_nxt = 1'b1;
          out_dev_nxt   = '0;
          out_found_nxt = 1'b0;
          out_err_nxt   = llds_pkg::ERR_NONE;
          out_cnt_nxt   = '0;
          state_nxt     = llds_pkg::ST_IDLE;
        end
      end
      llds_pkg::ST_APPLY: begin
        if (cmd_r == llds_pkg::CMD_DETACH) begin
          if (best_cnt_r == '0) begin
            upd_err = llds_pkg::ERR_UNDERFLOW;
          end else begin
            upd_cnt = best_cnt_r - 1'b1;
          end
        end else begin
          if (&best_cnt_r) begin
            upd_err = llds_pkg::ERR_OVERFLOW;
          end else begin
            upd_cnt = best_cnt_r + 1'b1;
          end
        end
        mem_ctl.wr_en = 1'b1;
        out_valid_nxt = 1'b1;
        out_dev_nxt   = best_idx_r;
        out_found_nxt = 1'b1;
        out_err_nxt   = upd_err;
        out_cnt_nxt   = llds_pkg::OUT_CNT_W'(upd_cnt);
        state_nxt     = llds_pkg::ST_IDLE;
      end
      default: begin
        state_nxt = llds_pkg::ST_IDLE;
      end
    endcase

    wr_data = upd_cnt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= llds_pkg::ST_IDLE;
      pend_r      <= 1'b0;
      have_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      pend_r      <= pend_nxt;
      have_r      <= have_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cmd_r       <= cmd_nxt;
    dev_r       <= dev_nxt;
    mask_r      <= mask_nxt;
    scan_idx_r  <= scan_idx_nxt;
    pend_idx_r  <= pend_idx_nxt;
    best_idx_r  <= best_idx_nxt;
    best_cnt_r  <= best_cnt_nxt;
    out_dev_r   <= out_dev_nxt;
    out_found_r <= out_found_nxt;
    out_err_r   <= out_err_nxt;
    out_cnt_r   <= out_cnt_nxt;
  end

  assign busy                = (state_r != llds_pkg::ST_IDLE);
  assign out_valid           = out_valid_r;
  assign out_selected_device = out_dev_r;
  assign out_found           = out_found_r;
  assign out_error_code      = out_err_r;
  assign out_new_count       = out_cnt_r;

endmodule

[verif/tb_top.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the least loaded device selector: directed and
// random attach, detach and select commands, every result compared field by
// field against a local model of the per-device counters.
// ----------------------------------------------------------------------------

typedef struct packed {
  logic [llds_pkg::IDX_W-1:0]     device;
  logic                           found;
  logic [llds_pkg::ERR_W-1:0]     err;
  logic [llds_pkg::OUT_CNT_W-1:0] count;
} load_report_t;

class device_load_ledger;
  logic [llds_pkg::COUNT_WIDTH_DEF-1:0] load_counts [llds_pkg::NUM_DEVICES_DEF];
  load_report_t                         pending_reports[$];
  int unsigned                          fail_count;

  function new();
    foreach (load_counts[i]) load_counts[i] = '0;
    fail_count = 0;
  endfunction

  function logic [llds_pkg::ERR_W-1:0] raise_count(int idx);
    if (load_counts[idx] == {llds_pkg::COUNT_WIDTH_DEF{1'b1}}) return llds_pkg::ERR_OVERFLOW;
    load_counts[idx] = load_counts[idx] + 1'b1;
    return llds_pkg::ERR_NONE;
  endfunction

  function logic [llds_pkg::ERR_W-1:0] lower_count(int idx);
    if (load_counts[idx] == '0) return llds_pkg::ERR_UNDERFLOW;
    load_counts[idx] = load_counts[idx] - 1'b1;
    return llds_pkg::ERR_NONE;
  endfunction

  function void note_command(logic [llds_pkg::CMD_W-1:0] cmd,
                             logic [llds_pkg::IDX_W-1:0] dev,
                             logic [llds_pkg::MASK_W-1:0] mask);
    load_report_t r;
    int           best;
    bit           have;
    r    = '0;
    best = 0;
    have = 1'b0;
    case (cmd)
      llds_pkg::CMD_ATTACH, llds_pkg::CMD_DETACH: begin
        r.device = dev;
        if (int'(dev) < llds_pkg::NUM_DEVICES_DEF) begin
          r.found = 1'b1;
          r.err   = (cmd == llds_pkg::CMD_ATTACH) ? raise_count(dev) : lower_count(dev);
          r.count = load_counts[dev][llds_pkg::OUT_CNT_W-1:0];
        end
      end
      llds_pkg::CMD_SELECT: begin
        for (int i = 0; i < llds_pkg::MASK_W && i < llds_pkg::NUM_DEVICES_DEF; i++) begin
          if (mask[i] && (!have || load_counts[i] < load_counts[best])) begin
            best = i;
            have = 1'b1;
          end
        end
        if (have) begin
          r.device = best[llds_pkg::IDX_W-1:0];
          r.found  = 1'b1;
          r.err    = raise_count(best);
          r.count  = load_counts[best][llds_pkg::OUT_CNT_W-1:0];
        end
      end
      default: ;
    endcase
    pending_reports.push_back(r);
  endfunction

  function void check_result(load_report_t got);
    load_report_t exp;
    if (pending_reports.size() == 0) begin
      $error("result with no command pending: device %0d count %0d",
             got.device, got.count);
      fail_count++;
      return;
    end
    exp = pending_reports.pop_front();
    if (got.device !== exp.device) begin
      $error("selected_device: expected %0d, got %0d", exp.device, got.device);
      fail_count++;
    end
    if (got.found !== exp.found) begin
      $error("found: expected %0d, got %0d", exp.found, got.found);
      fail_count++;
    end
    if (got.err !== exp.err) begin
      $error("error_code: expected %0d, got %0d", exp.err, got.err);
      fail_count++;
    end
    if (got.count !== exp.count) begin
      $error("new_count: expected %0d, got %0d", exp.count, got.count);
      fail_count++;
    end
  endfunction
endclass

module tb_top;
  localparam int RANDOM_PER_PHASE = 350;
  localparam int SETTLE_CYCLES    = 24;
  localparam int CYCLE_LIMIT      = 250000;

  logic                           clk = 1'b0;
  logic                           rst_n;
  logic                           start;
  logic                           busy;
  logic [llds_pkg::CMD_W-1:0]     in_cmd;
  logic [llds_pkg::IDX_W-1:0]     in_device_index;
  logic [llds_pkg::MASK_W-1:0]    in_candidate_mask;
  logic                           out_valid;
  logic [llds_pkg::IDX_W-1:0]     out_selected_device;
  logic                           out_found;
  logic [llds_pkg::ERR_W-1:0]     out_error_code;
  logic [llds_pkg::OUT_CNT_W-1:0] out_new_count;

  device_load_ledger ledger;
  int unsigned       gap_percent;
  int unsigned       cycle_count;

  least_loaded_device_selector DUT (
    .clk                 (clk),
    .rst_n               (rst_n),
    .start               (start),
    .busy                (busy),
    .in_cmd              (in_cmd),
    .in_device_index     (in_device_index),
    .in_candidate_mask   (in_candidate_mask),
    .out_valid           (out_valid),
    .out_selected_device (out_selected_device),
    .out_found           (out_found),
    .out_error_code      (out_error_code),
    .out_new_count       (out_new_count)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  always @(posedge clk) begin
    if (rst_n === 1'b1 && out_valid === 1'b1) begin
      ledger.check_result({out_selected_device, out_found, out_error_code, out_new_count});
    end
  end

  // one command transfer; each cycle before it idles with gap_percent chance
  task automatic issue_command(input logic [llds_pkg::CMD_W-1:0] cmd,
                               input logic [llds_pkg::IDX_W-1:0] dev,
                               input logic [llds_pkg::MASK_W-1:0] mask);
    while ($urandom_range(99) < gap_percent) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start             <= 1'b1;
    in_cmd            <= cmd;
    in_device_index   <= dev;
    in_candidate_mask <= mask;
    do @(posedge clk); while (busy !== 1'b0);
    ledger.note_command(cmd, dev, mask);
  endtask

  task automatic issue_random_command();
    int unsigned                 pick;
    logic [llds_pkg::CMD_W-1:0]  cmd;
    logic [llds_pkg::MASK_W-1:0] mask;
    pick = $urandom_range(99);
    if (pick < 25)      cmd = llds_pkg::CMD_ATTACH;
    else if (pick < 60) cmd = llds_pkg::CMD_DETACH;
    else if (pick < 95) cmd = llds_pkg::CMD_SELECT;
    else                cmd = llds_pkg::CMD_NONE;
    case ($urandom_range(9))
      0:       mask = '0;
      1:       mask = llds_pkg::MASK_W'(1) << $urandom_range(llds_pkg::MASK_W - 1);
      2:       mask = '1;
      3:       mask = llds_pkg::MASK_W'($urandom) & llds_pkg::MASK_W'($urandom);
      default: mask = llds_pkg::MASK_W'($urandom);
    endcase
    issue_command(cmd, llds_pkg::IDX_W'($urandom_range(15)), mask);
  endtask

  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("Simulation FAILED");
    $finish;
  end

  initial begin
    ledger            = new();
    gap_percent       = 0;
    rst_n             = 1'b0;
    start             = 1'b0;
    in_cmd            = llds_pkg::CMD_ATTACH;
    in_device_index   = '0;
    in_candidate_mask = '0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: empty select, underflow, ties, edge masks, unused command
    issue_command(llds_pkg::CMD_SELECT, 4'd0, 16'h0000);
    issue_command(llds_pkg::CMD_DETACH, 4'd0, 16'h0000);
    issue_command(llds_pkg::CMD_ATTACH, 4'd0, 16'h0000);
    issue_command(llds_pkg::CMD_ATTACH, 4'd15, 16'hFFFF);
    issue_command(llds_pkg::CMD_SELECT, 4'd15, 16'hFFFF);
    issue_command(llds_pkg::CMD_SELECT, 4'd0, 16'h8001);
    issue_command(llds_pkg::CMD_SELECT, 4'd0, 16'h8000);
    issue_command(llds_pkg::CMD_NONE, 4'd15, 16'hFFFF);
    issue_command(llds_pkg::CMD_DETACH, 4'd15, 16'h0000);
    issue_command(llds_pkg::CMD_SELECT, 4'd9, 16'hFFFE);
    issue_command(llds_pkg::CMD_SELECT, 4'd0, 16'h0001);
    issue_command(llds_pkg::CMD_DETACH, 4'd1, 16'hFFFF);
    issue_command(llds_pkg::CMD_DETACH, 4'd1, 16'hFFFF);
    issue_command(llds_pkg::CMD_SELECT, 4'd0, 16'h0003);
    issue_command(llds_pkg::CMD_NONE, 4'd0, 16'h0000);
    issue_command(llds_pkg::CMD_SELECT, 4'd0, 16'hAAAA);
    issue_command(llds_pkg::CMD_SELECT, 4'd0, 16'h5555);

    gap_percent = 21;
    repeat (RANDOM_PER_PHASE) issue_random_command();
    gap_percent = 76;
    repeat (RANDOM_PER_PHASE) issue_random_command();
    gap_percent = 0;
    repeat (RANDOM_PER_PHASE) issue_random_command();
    start <= 1'b0;

    while (ledger.pending_reports.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (ledger.fail_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end
endmodule

[sim.f]
rtl/core/llds_pkg.sv
rtl/core/llds_count_mem.sv
rtl/core/least_loaded_device_selector.sv
verif/tb_top.sv
